>>> rtl/core/polynomial_string_hash_core_macros.svh
// Assertion macros for the polynomial string hash core checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef POLYNOMIAL_STRING_HASH_CORE_MACROS_SVH
`define POLYNOMIAL_STRING_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PHS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PHS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/phs_pkg.sv
// Package for the polynomial string hash core: constants, control codes,
// control word and status types, and the microcode program. No dependencies.
`default_nettype none

package phs_pkg;

  localparam int unsigned BucketBits = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned StepBits   = 4;

  localparam logic [29:0] HashMod    = 30'd1000000009;
  localparam logic [4:0]  HashBase   = 5'd31;
  localparam logic [8:0]  CoefOffset = 9'd96;   // 'a' - 1
  localparam logic [15:0] BucketRst  = 16'd101;

  // Reciprocal of the modulus, scaled by 2**50, for the quotient estimate.
  localparam logic [20:0] RecipK = 21'((64'd1 << 50) / 64'd1000000009);

  // Loop count start for the bucket remainder: one less than the 30 bits of the dividend magnitude.
  localparam logic [4:0] DivLastCnt = 5'd29;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MTERM,
    OP_MPOW,
    OP_ABS,
    OP_QEST,
    OP_MSUB,
    OP_FIXS,
    OP_FIXP,
    OP_DINIT,
    OP_DSTEP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_IN,
    C_BIG,
    C_NOT_LAST,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e                 op;
    cond_e               cond;
    logic [StepBits-1:0] target;
    logic                hold;   // suppress the op while the jump is taken
    logic                fin;    // fall through to step zero
  } ctl_word_t;

  typedef struct packed {
    op_e  op;
    logic en;
  } dp_ctl_t;

  typedef struct packed {
    logic big;
    logic last;
    logic cnt_nz;
  } dp_stat_t;

  typedef struct packed {
    logic [30:0]           hash;
    logic [BucketBits-1:0] rem;
    logic                  neg;
  } dp_res_t;

  // Step addresses of the program.
  localparam logic [StepBits-1:0] StIdle    = 4'd0;
  localparam logic [StepBits-1:0] StMterm   = 4'd1;
  localparam logic [StepBits-1:0] StAbs     = 4'd2;
  localparam logic [StepBits-1:0] StQestS   = 4'd3;
  localparam logic [StepBits-1:0] StMsubS   = 4'd4;
  localparam logic [StepBits-1:0] StFixSum  = 4'd5;
  localparam logic [StepBits-1:0] StMpow    = 4'd6;
  localparam logic [StepBits-1:0] StQestP   = 4'd7;
  localparam logic [StepBits-1:0] StMsubP   = 4'd8;
  localparam logic [StepBits-1:0] StFixPow  = 4'd9;
  localparam logic [StepBits-1:0] StDivInit = 4'd10;
  localparam logic [StepBits-1:0] StDivLoop = 4'd11;
  localparam logic [StepBits-1:0] StEmit    = 4'd12;

  function automatic ctl_word_t ucode_word(input logic [StepBits-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      StIdle:    w = '{op: OP_LOAD,  cond: C_NO_IN,    target: StIdle,    hold: 1'b1, fin: 1'b0};
      StMterm:   w = '{op: OP_MTERM, cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StAbs:     w = '{op: OP_ABS,   cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StQestS:   w = '{op: OP_QEST,  cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StMsubS:   w = '{op: OP_MSUB,  cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StFixSum:  w = '{op: OP_FIXS,  cond: C_BIG,      target: StFixSum,  hold: 1'b0, fin: 1'b0};
      StMpow:    w = '{op: OP_MPOW,  cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StQestP:   w = '{op: OP_QEST,  cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StMsubP:   w = '{op: OP_MSUB,  cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b0};
      StFixPow:  w = '{op: OP_FIXP,  cond: C_BIG,      target: StFixPow,  hold: 1'b0, fin: 1'b0};
      StDivInit: w = '{op: OP_DINIT, cond: C_NOT_LAST, target: StIdle,    hold: 1'b0, fin: 1'b0};
      StDivLoop: w = '{op: OP_DSTEP, cond: C_CNT_NZ,   target: StDivLoop, hold: 1'b0, fin: 1'b0};
      StEmit:    w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: StEmit,    hold: 1'b1, fin: 1'b1};
      default:   w = '{op: OP_NOP,   cond: C_NONE,     target: StIdle,    hold: 1'b0, fin: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/polynomial_string_hash_core.sv
// Polynomial rolling hash, one key byte per item, microcoded over a shared
// multiply and modular reduce datapath. Ready returns when the ten-step byte
// program ends, so a new byte is not taken before the last one is through.
// After the last byte the bucket remainder adds a 30-step bit-serial loop
// before the result is valid. Reset clears the sum to 0, the power to 1,
// the bucket count to 101 and empties the output register.
`default_nettype none

module polynomial_string_hash_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Key byte channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [7:0]                          char_byte_i,
  input  wire                                last_char_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [30:0]                 hash_value_o,
  output logic signed [phs_pkg::BucketBits:0] bucket_index_o,
  // Bucket count register
  input  wire                                cfg_we_i,
  input  wire [phs_pkg::CfgWidth-1:0]        cfg_wdata_i
);
  import phs_pkg::*;

  dp_ctl_t               ctl;
  dp_stat_t              stat;
  dp_res_t               res;

  logic [BucketBits-1:0] bucket_q;
  logic                  out_valid_q, out_valid_d;
  logic [30:0]           hash_q;
  logic [BucketBits:0]   bidx_q;
  logic                  out_busy;
  logic                  emit;
  logic [BucketBits:0]   rem_ext;
  logic [BucketBits:0]   bidx_w;

  // Bucket count: keep only the low bits that the remainder unit uses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= BucketBits'(BucketRst);
    end else if (cfg_we_i) begin
      bucket_q <= cfg_wdata_i[BucketBits-1:0];
    end
  end

  // Hold the emit step while the previous item still sits in the output register.
  assign out_busy = out_valid_q && !out_ready_i;

  phs_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_ready_o (in_ready_o)
  );

  phs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .char_byte_i    (char_byte_i),
    .last_char_i    (last_char_i),
    .bucket_count_i (bucket_q),
    .stat_o         (stat),
    .res_o          (res)
  );

  assign emit = ctl.en && (ctl.op == OP_EMIT);

  // Remainder takes the sign of the hash; a zero bucket count forces zero.
  assign rem_ext = {1'b0, res.rem};
  assign bidx_w  = (bucket_q == '0) ? '0 :
                   res.neg          ? (~rem_ext + (BucketBits+1)'(1)) : rem_ext;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload only on emit; it holds while the item waits.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      hash_q <= res.hash;
      bidx_q <= bidx_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = $signed(hash_q);
  assign bucket_index_o = $signed(bidx_q);

endmodule

`default_nettype wire

>>> rtl/core/phs_useq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on phs_pkg for the control word, condition codes and program.
`default_nettype none

module phs_useq (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               out_busy_i,
  input  phs_pkg::dp_stat_t stat_i,
  output phs_pkg::dp_ctl_t  ctl_o,
  output logic              in_ready_o
);
  import phs_pkg::*;

  logic [StepBits-1:0] pc_q, pc_d;
  ctl_word_t           word;
  logic                taken;

  assign word = ucode_word(pc_q);

  always_comb begin
    unique case (word.cond)
      C_NONE:     taken = 1'b0;
      C_NO_IN:    taken = !in_valid_i;
      C_BIG:      taken = stat_i.big;
      C_NOT_LAST: taken = !stat_i.last;
      C_CNT_NZ:   taken = stat_i.cnt_nz;
      C_OUT_BUSY: taken = out_busy_i;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = word.target;
    end else if (word.fin) begin
      pc_d = StIdle;
    end else begin
      pc_d = pc_q + StepBits'(1);
    end
  end

  assign ctl_o.op    = word.op;
  assign ctl_o.en    = !(word.hold && taken);
  assign in_ready_o  = (word.op == OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/phs_dpath.sv
// Datapath: hash state, shared multiply and modular reduce unit, and the
// bit-serial bucket remainder. Depends on phs_pkg for op codes and constants.
`default_nettype none

module phs_dpath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  phs_pkg::dp_ctl_t                  ctl_i,
  input  wire [7:0]                         char_byte_i,
  input  wire                               last_char_i,
  input  wire [phs_pkg::BucketBits-1:0]     bucket_count_i,
  output phs_pkg::dp_stat_t                 stat_o,
  output phs_pkg::dp_res_t                  res_o
);
  import phs_pkg::*;

  logic [7:0]            byte_q;
  logic                  last_q;
  logic signed [30:0]    sum_q, sum_d;
  logic [29:0]           pow_q, pow_d;
  logic signed [38:0]    acc_q, acc_d;
  logic [37:0]           mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [7:0]            qt_q, qt_d;
  logic [29:0]           dvd_q, dvd_d;
  logic [BucketBits-1:0] rem_q, rem_d;
  logic [4:0]            cnt_q, cnt_d;
  logic                  hneg_q, hneg_d;

  logic signed [8:0]     coef;
  logic signed [39:0]    term_full;
  logic [38:0]           qprod;
  logic [37:0]           qmul;
  logic                  big;
  logic [30:0]           mag31;
  logic [30:0]           sum_w;
  logic [BucketBits:0]   trial;
  logic [BucketBits:0]   dvsr;

  // Key byte as signed char, minus 'a', plus one.
  assign coef      = $signed({byte_q[7], byte_q}) - $signed(CoefOffset);
  assign term_full = 40'(coef) * 40'($signed({1'b0, pow_q}));
  assign qprod     = 39'(mag_q[37:20]) * 39'(RecipK);
  assign qmul      = 38'(qt_q) * 38'(HashMod);
  assign big       = (mag_q >= 38'(HashMod));
  assign mag31     = {1'b0, mag_q[29:0]};
  assign sum_w     = neg_q ? (~mag31 + 31'd1) : mag31;
  assign trial     = {rem_q, dvd_q[29]};
  assign dvsr      = {1'b0, bucket_count_i};

  always_comb begin
    sum_d  = sum_q;
    pow_d  = pow_q;
    acc_d  = acc_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    qt_d   = qt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    hneg_d = hneg_q;
    if (ctl_i.en) begin
      unique case (ctl_i.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
        end
        OP_MTERM: acc_d = 39'(term_full + 40'(sum_q));
        OP_MPOW: begin
          mag_d = 38'(pow_q) * 38'(HashBase);
          neg_d = 1'b0;
        end
        OP_ABS: begin
          mag_d = acc_q[38] ? 38'(-acc_q) : acc_q[37:0];
          neg_d = acc_q[38];
        end
        OP_QEST: qt_d = qprod[37:30];
        OP_MSUB: mag_d = mag_q - qmul;
        OP_FIXS: begin
          if (big) begin
            mag_d = mag_q - 38'(HashMod);
          end else begin
            sum_d = $signed(sum_w);
          end
        end
        OP_FIXP: begin
          if (big) begin
            mag_d = mag_q - 38'(HashMod);
          end else begin
            pow_d = mag_q[29:0];
          end
        end
        OP_DINIT: begin
          dvd_d  = sum_q[30] ? 30'(-sum_q) : sum_q[29:0];
          hneg_d = sum_q[30];
          rem_d  = '0;
          cnt_d  = DivLastCnt;
        end
        OP_DSTEP: begin
          rem_d = (trial >= dvsr) ? BucketBits'(trial - dvsr) : trial[BucketBits-1:0];
          dvd_d = {dvd_q[28:0], 1'b0};
          cnt_d = cnt_q - 5'd1;
        end
        OP_EMIT: begin
          sum_d = '0;
          pow_d = 30'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pow_q  <= 30'd1;
      last_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      sum_q <= sum_d;
      pow_q <= pow_d;
      cnt_q <= cnt_d;
      if (ctl_i.en && ctl_i.op == OP_LOAD) begin
        last_q <= last_char_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.op == OP_LOAD) begin
      byte_q <= char_byte_i;
    end
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    qt_q   <= qt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    hneg_q <= hneg_d;
  end

  assign stat_o.big    = big;
  assign stat_o.last   = last_q;
  assign stat_o.cnt_nz = (cnt_q != 5'd0);

  assign res_o.hash = sum_q;
  assign res_o.rem  = rem_q;
  assign res_o.neg  = hneg_q;

endmodule

`default_nettype wire

>>> rtl/core/phs_chk.sv
// Port-level checker for the polynomial string hash core, bound to the top.
// Depends on polynomial_string_hash_core_macros.svh and phs_pkg.
`default_nettype none
`include "polynomial_string_hash_core_macros.svh"

module phs_chk (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_o,
  input wire [7:0]                          char_byte_i,
  input wire                                last_char_i,
  input wire                                out_valid_o,
  input wire                                out_ready_i,
  input wire [30:0]                         hash_value_o,
  input wire [phs_pkg::BucketBits:0]        bucket_index_o,
  input wire                                cfg_we_i,
  input wire [phs_pkg::CfgWidth-1:0]        cfg_wdata_i
);
  import phs_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  `PHS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(hash_value_o) && $stable(bucket_index_o), "result item changed while stalled")
  `PHS_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_ready_o, "ready right after an accepted item")
  `PHS_ASSERT_NOW(a_busy_later, in_acc, ##4 !in_ready_o, "ready before the byte program ends")
  `PHS_ASSERT_NOW(a_sign, out_valid_o && !hash_value_o[30], !bucket_index_o[BucketBits], "bucket sign differs from hash sign")
  `PHS_ASSERT_NOW(a_zero, out_valid_o && hash_value_o == '0, bucket_index_o == '0, "nonzero bucket for zero hash")

endmodule

bind polynomial_string_hash_core phs_chk u_chk (.*);

`default_nettype wire

>>> test/tb.sv
// Testbench for polynomial_string_hash_core: streams keys byte by byte and
// checks every hash and bucket result against an in-file predictor.
// Depends on phs_pkg and the core RTL only.

module tb;

  // Hash arithmetic used by the predictor
  localparam longint HASH_PRIME   = 64'd1000000009;
  localparam longint HASH_RADIX   = 64'd31;
  localparam longint CHAR_BIAS    = 64'd96;       // 'a' - 1
  localparam logic [15:0] BUCKET_RESET = 16'd101;

  // Drain with margin after every result is back
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum int {KEY_LOWER, KEY_ANY, KEY_HIGH, KEY_LONG} key_kind_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_byte_t;

  typedef struct packed {
    logic signed [30:0]                  hash;
    logic signed [phs_pkg::BucketBits:0] bucket;
  } hash_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Key byte channel
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte = 8'h00;
  logic       last_char = 1'b0;

  // Result channel
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [30:0]                  hash_value;
  logic signed [phs_pkg::BucketBits:0] bucket_index;

  // Bucket count register
  logic                           cfg_we    = 1'b0;
  logic [phs_pkg::CfgWidth-1:0]   cfg_wdata = '0;

  // Pending key bytes and outstanding expected results
  key_byte_t    key_bytes[$];
  hash_result_t hash_expect[$];

  // Predictor state: per-key sum and power, plus the bucket count copy
  longint      key_sum      = 0;
  longint      key_power    = 1;
  logic [15:0] bucket_model = BUCKET_RESET;

  // Run control and bookkeeping
  logic no_idle     = 1'b0;
  logic hold_wanted = 1'b0;
  logic hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   send_gap    = 0;
  int   recv_gap    = 0;
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   queued_bytes = 0;
  int   bytes_sent   = 0;
  int   results_checked = 0;
  int   bucket_settings = 1;
  key_byte_t next_byte;

  polynomial_string_hash_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .char_byte_i   (char_byte),
    .last_char_i   (last_char),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .hash_value_o  (hash_value),
    .bucket_index_o(bucket_index),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run once the cycle limit is reached
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               hash_expect.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // Advance the hash by one byte; on the last byte queue the expected result
  // and clear the per-key state. Remainders truncate toward zero, so the sum
  // and the bucket keep the sign of the dividend.
  function automatic void step_hash(input logic [7:0] code, input logic last);
    longint       term;
    hash_result_t res;
    term      = (longint'($signed(code)) - CHAR_BIAS) * key_power;
    key_sum   = (key_sum + term) % HASH_PRIME;
    key_power = (key_power * HASH_RADIX) % HASH_PRIME;
    if (last) begin
      res.hash   = key_sum[30:0];
      res.bucket = (bucket_model != 16'd0) ?
                   (phs_pkg::BucketBits+1)'(key_sum % longint'(bucket_model)) : '0;
      hash_expect = {hash_expect, res};
      key_sum   = 0;
      key_power = 1;
    end
  endfunction

  // Driver: present the next pending byte after a random gap, and hold valid
  // and payload steady until the block takes the item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (in_valid && in_ready) begin
      step_hash(char_byte, last_char);
      bytes_sent++;
      send_gap = draw_gap();
      if (send_gap == 0 && key_bytes.size() != 0) begin
        // back-to-back: keep valid high, swap the payload
        next_byte = key_bytes.pop_front();
        char_byte <= next_byte.code;
        last_char <= next_byte.last;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (key_bytes.size() != 0) begin
        next_byte = key_bytes.pop_front();
        char_byte <= next_byte.code;
        last_char <= next_byte.last;
        in_valid  <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor only has to look at it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_wanted && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // draw the stall before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hash_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result hash=%0d bucket=%0d",
                                    hash_value, bucket_index));
        end else begin
          if (hash_value !== hash_expect[0].hash)
            report_mismatch($sformatf("hash_value got %0d want %0d",
                                      hash_value, hash_expect[0].hash));
          if (bucket_index !== hash_expect[0].bucket)
            report_mismatch($sformatf("bucket_index got %0d want %0d (count %0d)",
                                      bucket_index, hash_expect[0].bucket, bucket_model));
          void'(hash_expect.pop_front());
        end
        results_checked++;
        recv_gap = draw_gap();
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      out_ready <= (recv_gap == 0) && (hold_left == 0);
    end
  end

  task automatic push_byte(input logic [7:0] code, input logic last);
    key_byte_t kb;
    kb.code   = code;
    kb.last   = last;
    key_bytes = {key_bytes, kb};
    queued_bytes++;
  endtask

  task automatic queue_key(input key_kind_e kind);
    int         len;
    logic [7:0] code;
    case (kind)
      KEY_LOWER: len = $urandom_range(1, 12);
      KEY_LONG:  len = $urandom_range(20, 60);
      default:   len = $urandom_range(1, 16);
    endcase
    for (int i = 0; i < len; i++) begin
      case (kind)
        KEY_LOWER: code = 8'($urandom_range(97, 122));
        KEY_HIGH:  code = 8'($urandom_range(128, 255));
        default:   code = 8'($urandom);
      endcase
      push_byte(code, i == len - 1);
    end
  endtask

  // Write the bucket count while the block is idle
  task automatic write_bucket(input logic [15:0] count);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    bucket_model = count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    bucket_settings++;
  endtask

  // Wait until every byte is taken and every result is back, then let the
  // block settle before the next register write.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (key_bytes.size() != 0 || in_valid || hash_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Mostly lowercase keys, with arbitrary, high-byte and long keys mixed in
  task automatic run_random(input int count, input logic quiet);
    int        target;
    int        pick;
    key_kind_e kind;
    @(posedge clk_i);
    no_idle <= quiet;
    @(negedge clk_i);
    target = queued_bytes + count;
    while (queued_bytes < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      kind = KEY_LOWER;
      else if (pick < 16) kind = KEY_ANY;
      else if (pick < 19) kind = KEY_HIGH;
      else                kind = KEY_LONG;
      queue_key(kind);
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys at the reset bucket count
    @(negedge clk_i);
    push_byte(8'h61, 1'b1);          // 'a' alone hashes to 1
    push_byte(8'h60, 1'b1);          // zero coefficient
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b1);          // largest positive char
    push_byte(8'h80, 1'b1);          // most negative char
    push_byte(8'hFF, 1'b1);
    push_byte(8'h61, 1'b0);          // "abc"
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b1);
    for (int i = 0; i < 8; i++)      // negative sum with the power wrapping
      push_byte(8'h80, i == 7);
    push_byte(8'hFF, 1'b0);          // every bit both ways
    push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    wait_idle();

    run_random(250, 1'b0);
    write_bucket(16'd1);
    run_random(200, 1'b1);
    write_bucket(16'hFFFF);
    run_random(200, 1'b0);
    write_bucket(16'd0);             // zero bucket count: bucket stays 0
    run_random(150, 1'b0);

    // Hold the receiver for a long stretch while single-byte keys keep coming,
    // so the result register fills and the block stalls its input
    write_bucket(16'd7);
    @(posedge clk_i);
    hold_wanted <= 1'b1;
    no_idle     <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 30; i++)
      push_byte(8'($urandom), 1'b1);
    wait_idle();
    run_random(150, 1'b0);

    write_bucket(16'h8000);
    run_random(200, 1'b0);
    write_bucket(16'($urandom_range(2, 65534)));
    run_random(200, 1'b0);
    write_bucket(BUCKET_RESET);
    run_random(100, 1'b1);

    $display("covered %0d key bytes, %0d results checked, over %0d bucket counts",
             bytes_sent, results_checked, bucket_settings);
    $display("including zero, one and full-width counts and a long receiver stall");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
